[sv/lz5sd_pkg.sv]
// Package for the LZ5 sprite decompressor.
// Shared constants, register indexes and controller/datapath interface structs.
// No dependencies.
package lz5sd_pkg;

    localparam int WIN_DEPTH   = 1024;
    localparam int WIN_AW      = $clog2(WIN_DEPTH);
    localparam int PIX_PER_GRP = 8;
    localparam int GRP_W       = 64;
    localparam int CNT_W       = 4;
    localparam int DIM_W       = 15;
    localparam int LEN_W       = 2 * DIM_W;
    localparam int RUN_W       = 9;
    localparam int DIST_W      = 11;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EARLY = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    typedef struct packed {
        logic accept;
        logic rd;
        logic pix_wr;
        logic push_empty;
    } lz5sd_cmd_t;

    typedef struct packed {
        logic run;
        logic is_copy;
        logic empty;
        logic last_pix;
        logic out_free;
    } lz5sd_stat_t;

endpackage

[sv/lz5sd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lz5sd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/lz5sd_ctrl.sv]
// Controller state machine of the LZ5 sprite decompressor.
// Depends on lz5sd_pkg.
module lz5sd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lz5sd_pkg::lz5sd_stat_t stat,
    output lz5sd_pkg::lz5sd_cmd_t  cmd
);
    import lz5sd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LIT   = 3'd1;
    localparam logic [2:0] S_CRD   = 3'd2;
    localparam logic [2:0] S_CWR   = 3'd3;
    localparam logic [2:0] S_EMPTY = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    if (stat.run) begin
                        state_next = stat.is_copy ? S_CRD : S_LIT;
                    end else if (stat.empty) begin
                        state_next = S_EMPTY;
                    end
                end
            end
            S_LIT: begin
                if (stat.out_free) begin
                    cmd.pix_wr = 1'b1;
                    if (stat.last_pix) state_next = S_IDLE;
                end
            end
            S_CRD: begin
                cmd.rd     = 1'b1;
                state_next = S_CWR;
            end
            S_CWR: begin
                if (stat.out_free) begin
                    cmd.pix_wr = 1'b1;
                    state_next = stat.last_pix ? S_IDLE : S_CRD;
                end
            end
            S_EMPTY: begin
                if (stat.out_free) begin
                    cmd.push_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/lz5sd_dp.sv]
// Datapath of the LZ5 sprite decompressor: token decode, run counters,
// history window, pixel grouping and the output register. Depends on lz5sd_pkg, lz5sd_ram.
module lz5sd_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [0:0]                cfg_index,
    input  logic [lz5sd_pkg::DIM_W-1:0] cfg_wr_data,
    input  logic [7:0]                s_src_byte,
    input  logic                      s_last_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [lz5sd_pkg::GRP_W-1:0] m_pixel_group,
    output logic [lz5sd_pkg::CNT_W-1:0] m_pixel_count,
    output logic                      m_run_end,
    output logic                      m_image_done,
    output logic [1:0]                m_status,
    input  lz5sd_pkg::lz5sd_cmd_t     cmd,
    output lz5sd_pkg::lz5sd_stat_t    stat
);
    import lz5sd_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] width_next, height_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] pw_reg, pw_next;

    logic [7:0] flag_bits_reg, flag_bits_next;
    logic [2:0] flag_pos_reg, flag_pos_next;
    logic       expect_reg, expect_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [7:0] carry_reg, carry_next;
    logic [2:0] cbc_reg, cbc_next;

    logic [RUN_W-1:0]  rem_reg, rem_next;
    logic              copy_reg, copy_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [4:0]        val_reg, val_next;
    logic              lastp_reg, lastp_next;
    logic              bad_rd_reg;

    logic [GRP_W-1:0] grp_px_reg, grp_px_next;
    logic [CNT_W-1:0] grp_cnt_reg, grp_cnt_next;
    logic             grp_bad_reg, grp_bad_next;

    logic             m_valid_reg;
    logic [GRP_W-1:0] out_px_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic             out_end_reg, out_done_reg;
    logic [1:0]       out_st_reg;

    logic             full, copy_bit, run, tok_done;
    logic [LEN_W-1:0] pw_inc, src_pos;
    logic             done_now, last_pix, close, pix_bad;
    logic [7:0]       pix_val, ram_rdata;
    logic [GRP_W-1:0] grp_ins;
    logic [CNT_W-1:0] cnt_inc;
    logic             out_free;
    logic [7:0]       d;

    assign d        = s_src_byte;
    assign full     = pw_reg >= len_reg;
    assign copy_bit = flag_bits_reg[flag_pos_reg];
    assign pw_inc   = pw_reg + LEN_W'(1);
    assign done_now = pw_inc >= len_reg;
    assign last_pix = (rem_reg == RUN_W'(1)) || done_now;
    assign src_pos  = pw_reg - LEN_W'(dist_reg);
    assign out_free = !m_valid_reg || m_ready;

    // The image length follows a size write in the same cycle as the size itself.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WIDTH:  width_next  = cfg_wr_data;
                REG_HEIGHT: height_next = cfg_wr_data;
            endcase
        end
    end

    // Token decode for the byte at the input; state changes take effect on accept.
    always_comb begin
        flag_bits_next = flag_bits_reg;
        flag_pos_next  = flag_pos_reg;
        expect_next    = expect_reg;
        phase_next     = phase_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        carry_next     = carry_reg;
        cbc_next       = cbc_reg;
        rem_next       = rem_reg;
        copy_next      = copy_reg;
        dist_next      = dist_reg;
        val_next       = val_reg;
        run            = 1'b0;
        tok_done       = 1'b0;
        if (full) begin
            run = 1'b0;
        end else if (expect_reg) begin
            flag_bits_next = d;
            flag_pos_next  = '0;
            expect_next    = 1'b0;
        end else if (phase_reg == 2'd0) begin
            if (copy_bit) begin
                if (d[5:0] == 6'd0) begin
                    first_next = d;
                    phase_next = 2'd1;
                end else if (cbc_reg >= 3'd6) begin
                    dist_next  = DIST_W'({carry_reg[7:2], d[7:6]}) + DIST_W'(1);
                    carry_next = '0;
                    cbc_next   = '0;
                    rem_next   = RUN_W'(d[5:0]) + RUN_W'(1);
                    copy_next  = 1'b1;
                    run        = 1'b1;
                    tok_done   = 1'b1;
                end else begin
                    carry_next = carry_reg | ({d[7:6], 6'd0} >> cbc_reg);
                    cbc_next   = cbc_reg + 3'd2;
                    first_next = d;
                    phase_next = 2'd1;
                end
            end else begin
                if (d[7:5] == 3'd0) begin
                    first_next = d;
                    phase_next = 2'd1;
                end else begin
                    rem_next  = RUN_W'(d[7:5]);
                    val_next  = d[4:0];
                    copy_next = 1'b0;
                    run       = 1'b1;
                    tok_done  = 1'b1;
                end
            end
        end else if (phase_reg == 2'd1) begin
            if (copy_bit) begin
                if (first_reg[5:0] == 6'd0) begin
                    second_next = d;
                    phase_next  = 2'd2;
                end else begin
                    rem_next  = RUN_W'(first_reg[5:0]) + RUN_W'(1);
                    dist_next = DIST_W'(d) + DIST_W'(1);
                    copy_next = 1'b1;
                    run       = 1'b1;
                    tok_done  = 1'b1;
                end
            end else begin
                rem_next  = RUN_W'(d) + RUN_W'(8);
                val_next  = first_reg[4:0];
                copy_next = 1'b0;
                run       = 1'b1;
                tok_done  = 1'b1;
            end
        end else begin
            rem_next  = RUN_W'(d) + RUN_W'(3);
            dist_next = DIST_W'({first_reg[7:6], second_reg}) + DIST_W'(1);
            copy_next = 1'b1;
            run       = 1'b1;
            tok_done  = 1'b1;
        end
        if (tok_done) begin
            phase_next = 2'd0;
            if (flag_pos_reg == 3'd7) begin
                flag_pos_next = '0;
                expect_next   = 1'b1;
            end else begin
                flag_pos_next = flag_pos_reg + 3'd1;
            end
        end
        // The last source byte re-arms the token state; the pixel position is cleared
        // at the end of its run.
        if (s_last_byte) begin
            flag_bits_next = '0;
            flag_pos_next  = '0;
            expect_next    = 1'b1;
            phase_next     = '0;
            first_next     = '0;
            second_next    = '0;
            carry_next     = '0;
            cbc_next       = '0;
        end
        lastp_next = s_last_byte;
    end

    assign stat.run      = run;
    assign stat.is_copy  = copy_next;
    assign stat.empty    = s_last_byte && !full && !run;
    assign stat.last_pix = last_pix;
    assign stat.out_free = out_free;

    assign pix_bad = copy_reg && bad_rd_reg;
    assign pix_val = !copy_reg ? {3'd0, val_reg} : (bad_rd_reg ? 8'd0 : ram_rdata);
    assign cnt_inc = grp_cnt_reg + CNT_W'(1);
    assign close   = (cnt_inc == CNT_W'(PIX_PER_GRP)) || last_pix;

    always_comb begin
        grp_ins = grp_px_reg;
        for (int i = 0; i < PIX_PER_GRP; i++) begin
            if (grp_cnt_reg == CNT_W'(i)) grp_ins[i*8 +: 8] = pix_val;
        end
    end

    always_comb begin
        grp_px_next  = grp_px_reg;
        grp_cnt_next = grp_cnt_reg;
        grp_bad_next = grp_bad_reg;
        pw_next      = pw_reg;
        if (cmd.accept && s_last_byte && !run) begin
            pw_next = '0;
        end
        if (cmd.pix_wr) begin
            pw_next = (last_pix && lastp_reg) ? '0 : pw_inc;
            if (close) begin
                grp_px_next  = '0;
                grp_cnt_next = '0;
                grp_bad_next = 1'b0;
            end else begin
                grp_px_next  = grp_ins;
                grp_cnt_next = cnt_inc;
                grp_bad_next = grp_bad_reg || pix_bad;
            end
        end
    end

    lz5sd_ram #(
        .WIDTH(8),
        .DEPTH(WIN_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (cmd.pix_wr),
        .waddr (pw_reg[WIN_AW-1:0]),
        .wdata (pix_val),
        .raddr (src_pos[WIN_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            bad_rd_reg <= LEN_W'(dist_reg) > pw_reg;
        end
        if (cmd.accept) begin
            rem_reg   <= rem_next;
            copy_reg  <= copy_next;
            dist_reg  <= dist_next;
            val_reg   <= val_next;
            lastp_reg <= lastp_next;
        end else if (cmd.pix_wr) begin
            rem_reg <= rem_reg - RUN_W'(1);
        end
        if (cmd.pix_wr && close) begin
            out_px_reg   <= grp_ins;
            out_cnt_reg  <= cnt_inc;
            out_end_reg  <= last_pix;
            out_done_reg <= done_now;
            if (last_pix && lastp_reg && !done_now) begin
                out_st_reg <= STATUS_SHORT;
            end else begin
                out_st_reg <= (grp_bad_reg || pix_bad) ? STATUS_EARLY : STATUS_OK;
            end
        end else if (cmd.push_empty) begin
            out_px_reg   <= '0;
            out_cnt_reg  <= '0;
            out_end_reg  <= 1'b1;
            out_done_reg <= 1'b0;
            out_st_reg   <= STATUS_SHORT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= '0;
            height_reg    <= '0;
            len_reg       <= '0;
            pw_reg        <= '0;
            flag_bits_reg <= '0;
            flag_pos_reg  <= '0;
            expect_reg    <= 1'b1;
            phase_reg     <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            carry_reg     <= '0;
            cbc_reg       <= '0;
            grp_px_reg    <= '0;
            grp_cnt_reg   <= '0;
            grp_bad_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            len_reg     <= LEN_W'(width_next) * LEN_W'(height_next);
            pw_reg      <= pw_next;
            grp_px_reg  <= grp_px_next;
            grp_cnt_reg <= grp_cnt_next;
            grp_bad_reg <= grp_bad_next;
            if (cmd.accept) begin
                flag_bits_reg <= flag_bits_next;
                flag_pos_reg  <= flag_pos_next;
                expect_reg    <= expect_next;
                phase_reg     <= phase_next;
                first_reg     <= first_next;
                second_reg    <= second_next;
                carry_reg     <= carry_next;
                cbc_reg       <= cbc_next;
            end
            if ((cmd.pix_wr && close) || cmd.push_empty) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_group = out_px_reg;
    assign m_pixel_count = out_cnt_reg;
    assign m_run_end     = out_end_reg;
    assign m_image_done  = out_done_reg;
    assign m_status      = out_st_reg;

endmodule

[sv/lz5_sprite_decompressor_top.sv]
// Top level of the LZ5 sprite decompressor.
// Depends on lz5sd_pkg, lz5sd_ctrl, lz5sd_dp (which holds lz5sd_ram).
//
//  Port group   Direction  Handshake          Carries
//  s_*          in         s_valid/s_ready    one compressed byte and its last flag
//  m_*          out        m_valid/m_ready    up to eight pixels with count and status
//  cfg_*        in         cfg_wr_en          image width and height
//
// A byte is taken while the controller is idle; a byte that starts a run then
// holds the input until its run is written, the copy states reading history
// (S_CRD) before each write (S_CWR) since the RAM read is registered. Runs span
// 1 to 263 pixels. A result waiting in the output register stalls pixel
// generation until it is taken. Reset is synchronous; history is not cleared.
module lz5_sprite_decompressor_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [0:0]                  cfg_index,
    input  logic [lz5sd_pkg::DIM_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_src_byte,
    input  logic                        s_last_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lz5sd_pkg::GRP_W-1:0] m_pixel_group,
    output logic [lz5sd_pkg::CNT_W-1:0] m_pixel_count,
    output logic                        m_run_end,
    output logic                        m_image_done,
    output logic [1:0]                  m_status
);
    import lz5sd_pkg::*;

    lz5sd_cmd_t  cmd;
    lz5sd_stat_t stat;

    lz5sd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lz5sd_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_src_byte    (s_src_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_group (m_pixel_group),
        .m_pixel_count (m_pixel_count),
        .m_run_end     (m_run_end),
        .m_image_done  (m_image_done),
        .m_status      (m_status),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

[sv/lz5sd_checker.sv]
// Port-level checks for the LZ5 sprite decompressor, bound to the top level.
// Depends on lz5sd_pkg.
module lz5sd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [lz5sd_pkg::GRP_W-1:0] m_pixel_group,
    input logic [lz5sd_pkg::CNT_W-1:0] m_pixel_count,
    input logic                        m_run_end,
    input logic                        m_image_done,
    input logic [1:0]                  m_status
);
    import lz5sd_pkg::*;

    // A stalled transaction keeps its pixels.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_group))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pixel_count <= CNT_W'(PIX_PER_GRP))
        else $error("pixel count out of range");

    // The group with the final pixel always ends its run and never has the short status.
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_image_done |-> m_run_end && m_status != STATUS_SHORT)
        else $error("image done without run end");

    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_SHORT |-> m_run_end)
        else $error("early end status not on last result");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pixel_count == '0 |-> m_status == STATUS_SHORT && m_pixel_group == '0)
        else $error("empty group without early end status");

endmodule

bind lz5_sprite_decompressor_top lz5sd_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_group (m_pixel_group),
    .m_pixel_count (m_pixel_count),
    .m_run_end     (m_run_end),
    .m_image_done  (m_image_done),
    .m_status      (m_status)
);
